// ===== src/b64d_pkg.sv =====
// Shared types, codes and the alphabet lookup of the base64 stream decoder.
package b64d_pkg;

   localparam int COUNT_WIDTH_DEF = 16;

   localparam logic       CMD_TEXT     = 1'b0;
   localparam logic       CMD_END      = 1'b1;
   localparam logic       KIND_DATA    = 1'b0;
   localparam logic       KIND_STATUS  = 1'b1;
   localparam logic [7:0] PAD_CHAR     = 8'h3d;   // '='
   localparam logic [6:0] NO_SEXTET    = 7'd64;
   localparam logic [15:0] CAP_RESET   = 16'hffff;

   typedef struct packed {
      logic        kind;
      logic [7:0]  data_byte;
      logic        failed;
      logic [15:0] byte_total;
      logic        last;
   } result_type;

   // Up to three result words made by one item, oldest in word[0].
   typedef struct packed {
      logic [1:0]           count;
      result_type [2:0]     word;
   } burst_type;

   function automatic logic [6:0] sextet_of(input logic [7:0] c);
      logic [6:0] s;
      s = NO_SEXTET;
      if (c inside {[8'h41:8'h5a]}) begin
         s = 7'(c - 8'h41);
      end else if (c inside {[8'h61:8'h7a]}) begin
         s = 7'(c - 8'h61 + 8'd26);
      end else if (c inside {[8'h30:8'h39]}) begin
         s = 7'(c - 8'h30 + 8'd52);
      end else if (c == 8'h2b) begin
         s = 7'd62;
      end else if (c == 8'h2f) begin
         s = 7'd63;
      end
      return s;
   endfunction

   function automatic result_type make_data(input logic [7:0] b);
      result_type r;
      r.kind       = KIND_DATA;
      r.data_byte  = b;
      r.failed     = 1'b0;
      r.byte_total = 16'd0;
      r.last       = 1'b0;
      return r;
   endfunction

   function automatic result_type make_status(input logic fail, input logic [15:0] total);
      result_type r;
      r.kind       = KIND_STATUS;
      r.data_byte  = 8'd0;
      r.failed     = fail;
      r.byte_total = fail ? 16'd0 : total;
      r.last       = 1'b1;
      return r;
   endfunction

endpackage

// ===== src/b64d_core.sv =====
// Decode logic and per-text state: one item in, a burst of result words out.
module b64d_core #(
   parameter int COUNT_WIDTH = b64d_pkg::COUNT_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_command,
   input  logic [7:0]            item_char,
   input  logic [15:0]           capacity,
   input  logic                  advance,
   output b64d_pkg::burst_type   burst
);
   import b64d_pkg::*;

   localparam int CMP_W = ((COUNT_WIDTH > 16) ? COUNT_WIDTH : 16) + 1;

   logic [1:0]             pos_ff, pos_in;
   logic [17:0]            acc_ff, acc_in;
   logic [1:0]             pad_ff, pad_in;
   logic                   pdone_ff, pdone_in;
   logic [15:0]            pend_ff, pend_in;
   logic [1:0]             pcnt_ff, pcnt_in;
   logic                   err_ff, err_in;
   logic [COUNT_WIDTH-1:0] emit_ff, emit_in;

   logic                   is_pad;
   logic [6:0]             sx;
   logic [5:0]             s6;
   logic [1:0]             pad_nx;
   logic [23:0]            quad;
   logic [CMP_W-1:0]       emit_x;
   logic [CMP_W-1:0]       cap_x;
   logic                   fits1, fits2, fits3;
   logic [COUNT_WIDTH-1:0] total_sum;
   logic [15:0]            total16;
   logic                   end_bad;

   always_comb begin
      is_pad    = (item_char == PAD_CHAR);
      sx        = sextet_of(item_char);
      s6        = is_pad ? 6'd0 : sx[5:0];
      pad_nx    = pad_ff + {1'b0, is_pad};
      quad      = {acc_ff, s6};
      emit_x    = CMP_W'(emit_ff);
      cap_x     = CMP_W'(capacity);
      fits1     = (emit_x + CMP_W'(1)) <= cap_x;
      fits2     = (emit_x + CMP_W'(2)) <= cap_x;
      fits3     = (emit_x + CMP_W'(3)) <= cap_x;
      total_sum = emit_ff + COUNT_WIDTH'(pcnt_ff);
      total16   = 16'(total_sum);
      end_bad   = err_ff | (pos_ff != 2'd0);

      pos_in   = pos_ff;
      acc_in   = acc_ff;
      pad_in   = pad_ff;
      pdone_in = pdone_ff;
      pend_in  = pend_ff;
      pcnt_in  = pcnt_ff;
      err_in   = err_ff;
      emit_in  = emit_ff;

      burst.count   = 2'd0;
      burst.word[0] = make_status(1'b1, 16'd0);
      burst.word[1] = make_status(1'b1, 16'd0);
      burst.word[2] = make_status(1'b1, 16'd0);

      if (item_command == CMD_END) begin
         // End of text: flush held bytes on success, then the status word.
         if (end_bad) begin
            burst.count   = 2'd1;
            burst.word[0] = make_status(1'b1, 16'd0);
         end else if (pcnt_ff == 2'd2) begin
            burst.count   = 2'd3;
            burst.word[0] = make_data(pend_ff[15:8]);
            burst.word[1] = make_data(pend_ff[7:0]);
            burst.word[2] = make_status(1'b0, total16);
         end else if (pcnt_ff == 2'd1) begin
            burst.count   = 2'd2;
            burst.word[0] = make_data(pend_ff[15:8]);
            burst.word[1] = make_status(1'b0, total16);
         end else begin
            burst.count   = 2'd1;
            burst.word[0] = make_status(1'b0, total16);
         end
         pos_in   = 2'd0;
         acc_in   = 18'd0;
         pad_in   = 2'd0;
         pdone_in = 1'b0;
         pend_in  = 16'd0;
         pcnt_in  = 2'd0;
         err_in   = 1'b0;
         emit_in  = '0;
      end else if (err_ff) begin
         // swallowed until end of text
      end else if (pdone_ff) begin
         err_in = 1'b1;
      end else if (!is_pad && sx == NO_SEXTET) begin
         err_in = 1'b1;
      end else if (is_pad && pos_ff < 2'd2) begin
         err_in = 1'b1;
      end else if (!is_pad && pad_ff != 2'd0) begin
         err_in = 1'b1;
      end else if (pos_ff != 2'd3) begin
         acc_in = {acc_ff[11:0], s6};
         pos_in = pos_ff + 2'd1;
         pad_in = pad_nx;
      end else begin
         pos_in = 2'd0;
         acc_in = 18'd0;
         pad_in = pad_nx;
         if (pad_nx == 2'd0) begin
            if (!fits3) begin
               err_in = 1'b1;
            end else begin
               burst.count   = 2'd3;
               burst.word[0] = make_data(quad[23:16]);
               burst.word[1] = make_data(quad[15:8]);
               burst.word[2] = make_data(quad[7:0]);
               emit_in       = emit_ff + COUNT_WIDTH'(3);
            end
         end else if (pad_nx == 2'd1) begin
            if (!fits2) begin
               err_in = 1'b1;
            end else begin
               pend_in  = quad[23:8];
               pcnt_in  = 2'd2;
               pdone_in = 1'b1;
            end
         end else begin
            if (!fits1) begin
               err_in = 1'b1;
            end else begin
               pend_in  = {quad[23:16], 8'd0};
               pcnt_in  = 2'd1;
               pdone_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= 2'd0;
         acc_ff   <= 18'd0;
         pad_ff   <= 2'd0;
         pdone_ff <= 1'b0;
         pend_ff  <= 16'd0;
         pcnt_ff  <= 2'd0;
         err_ff   <= 1'b0;
         emit_ff  <= '0;
      end else if (advance) begin
         pos_ff   <= pos_in;
         acc_ff   <= acc_in;
         pad_ff   <= pad_in;
         pdone_ff <= pdone_in;
         pend_ff  <= pend_in;
         pcnt_ff  <= pcnt_in;
         err_ff   <= err_in;
         emit_ff  <= emit_in;
      end
   end

`ifndef ASSERT_OFF
   // Held bytes exist exactly when a padded quad has completed.
   a_pend_match: assert property (@(posedge clock) disable iff (reset)
      (pcnt_ff != 2'd0) == pdone_ff)
      else $error("held byte count disagrees with padded quad flag");
   // Padding is only ever seen at the last two quad positions.
   a_pad_max: assert property (@(posedge clock) disable iff (reset)
      pad_ff != 2'd3)
      else $error("pad count out of range");
   // Once a padded quad is done, no further quad can be in progress.
   a_pdone_pos: assert property (@(posedge clock) disable iff (reset)
      pdone_ff |-> pos_ff == 2'd0)
      else $error("quad started after padding");
`endif

endmodule

// ===== src/b64d_out_buf.sv =====
// Result register: holds a burst of up to three words and drains one per cycle while rsp_stall is low.
module b64d_out_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  b64d_pkg::burst_type   burst,
   input  logic                  rsp_stall,
   output logic                  free,
   output logic                  rsp_valid,
   output b64d_pkg::result_type  head
);
   import b64d_pkg::*;

   result_type [2:0] word_ff, word_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             pop;

   always_comb begin
      pop       = (cnt_ff != 2'd0) & ~rsp_stall;
      free      = (cnt_ff == 2'd0) | ((cnt_ff == 2'd1) & pop);
      rsp_valid = (cnt_ff != 2'd0);
      head      = word_ff[0];
      word_in   = word_ff;
      cnt_in    = cnt_ff;
      if (load) begin
         word_in = burst.word;
         cnt_in  = burst.count;
      end else if (pop) begin
         word_in[0] = word_ff[1];
         word_in[1] = word_ff[2];
         cnt_in     = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

`ifndef ASSERT_OFF
   // A burst is only loaded once the previous one is fully taken.
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load |-> free)
      else $error("burst loaded over pending words");
   // A failed status never reports a byte total.
   a_fail_total: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && head.kind == KIND_STATUS && head.failed) |-> head.byte_total == 16'd0)
      else $error("failed status with nonzero total");
   // Status words are always flagged last, data words never.
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> head.last == head.kind)
      else $error("last flag does not follow word kind");
`endif

endmodule

// ===== src/base64_stream_decoder_unit.sv =====
// Top level of the streaming base64 decoder.
//
// Usage:
//  - req_ channel: one word per character (req_command = 0, req_char_code =
//    ASCII code), closed by one end-of-text word (req_command = 1).
//  - rsp_ channel: decoded bytes (rsp_kind = 0) as quads complete, then one
//    status word (rsp_kind = 1, rsp_last = 1) per end-of-text with
//    rsp_failed and rsp_byte_total. Bytes of a padded final quad come out
//    only with the end-of-text word.
//  - csr_ channel: writes the byte capacity; always ready. Write it only
//    while the decoder is idle.
// An accepted word is held in the input register and decoded there; its
// results are registered in the result buffer and presented from it.
// Throughput: one input word per cycle as long as the result buffer can
// take its burst; a word that yields k results (at most 3) holds the result
// port until all k have drained, one word per cycle while rsp_stall is
// low. Words that yield nothing never wait on the result side.
// Reset: all per-text state cleared, capacity back to 65535, no results
// pending. When rsp_stall is high the current result holds; the decoder
// keeps absorbing words until a new burst needs the result buffer, and only
// then raises req_stall.
module base64_stream_decoder_unit #(
   parameter int COUNT_WIDTH = b64d_pkg::COUNT_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [7:0]  req_char_code,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_failed,
   output logic [15:0] rsp_byte_total,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_capacity
);
   import b64d_pkg::*;

   // input register
   logic        in_vld_ff, in_vld_in;
   logic        cmd_ff;
   logic [7:0]  char_ff;
   logic [15:0] cap_ff;

   logic        accept;
   logic        advance;
   logic        buf_free;
   logic        load;
   burst_type   burst;
   result_type  head;

   // An item leaves the input register when its results (if any) fit into
   // the result buffer; silent items always pass.
   assign advance   = in_vld_ff & ((burst.count == 2'd0) | buf_free);
   assign load      = advance & (burst.count != 2'd0);
   assign req_stall = in_vld_ff & ~advance;
   assign accept    = req_valid & ~req_stall;
   assign in_vld_in = accept | (in_vld_ff & ~advance);
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         cap_ff    <= CAP_RESET;
      end else begin
         in_vld_ff <= in_vld_in;
         if (csr_valid) begin
            cap_ff <= csr_capacity;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_command;
         char_ff <= req_char_code;
      end
   end

   b64d_core #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .item_command (cmd_ff),
      .item_char    (char_ff),
      .capacity     (cap_ff),
      .advance      (advance),
      .burst        (burst)
   );

   b64d_out_buf u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .burst     (burst),
      .rsp_stall (rsp_stall),
      .free      (buf_free),
      .rsp_valid (rsp_valid),
      .head      (head)
   );

   assign rsp_kind       = head.kind;
   assign rsp_data_byte  = head.data_byte;
   assign rsp_failed     = head.failed;
   assign rsp_byte_total = head.byte_total;
   assign rsp_last       = head.last;

`ifndef ASSERT_OFF
   // A word waiting in the input register is stalled only behind a busy buffer.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_vld_ff && !buf_free))
      else $error("input stalled without a busy result buffer");
   // A stalled input word stays in the input register.
   a_hold_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> in_vld_ff)
      else $error("stalled word was dropped");
   // An end-of-text word always produces at least its status word.
   a_end_status: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && cmd_ff == CMD_END) |-> burst.count != 2'd0)
      else $error("end of text without status");
`endif

endmodule
